// ===== design/button_autorepeat_timer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button auto-repeat timer
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AUTOREPEAT_TIMER_MACROS_SVH
`define BUTTON_AUTOREPEAT_TIMER_MACROS_SVH

// Same-cycle implication
`define BAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication
`define BAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

// ===== design/bat_pkg.sv =====
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and constants of the button auto-repeat timer.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int DELAY_BITS = 24;
    localparam int LEVEL_BITS = 32;
    localparam int INDEX_BITS = 5;
    localparam int COUNT_BITS = 6;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_PRESS_DELAY    = 2'd0;
    localparam t_reg_idx REG_REPEAT_INTERVAL = 2'd1;
    localparam t_reg_idx REG_RELEASE_DELAY  = 2'd2;
    localparam t_reg_idx REG_ACTIVE_BUTTONS = 2'd3;

    localparam logic [COUNT_BITS-1:0] ACTIVE_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_seq_state;

    // Button condition fed to the shared unit
    typedef struct packed {
        logic pressed;
        logic last;
    } t_step_in;

    // Decision returned by the shared unit
    typedef struct packed {
        logic hit;
        logic level;
    } t_step_res;

endpackage

// ===== design/bat_unit.sv =====
// ----------------------------------------------------------------------------
// bat_unit
// Shared time unit: picks the wait, adds elapsed ticks with saturation and
// tests and subtracts the wait for the button under scan.
// ----------------------------------------------------------------------------
module bat_unit #(
    parameter int TIME_BITS = 24
) (
    input  logic [TIME_BITS-1:0]           i_acc,
    input  logic [bat_pkg::DELAY_BITS-1:0] i_dt,
    input  logic [bat_pkg::DELAY_BITS-1:0] i_press_delay,
    input  logic [bat_pkg::DELAY_BITS-1:0] i_repeat_interval,
    input  logic [bat_pkg::DELAY_BITS-1:0] i_release_delay,
    input  bat_pkg::t_step_in              i_cond,
    output logic [TIME_BITS-1:0]           o_acc,
    output bat_pkg::t_step_res             o_res
);

    localparam int SW = (TIME_BITS > bat_pkg::DELAY_BITS) ? TIME_BITS : bat_pkg::DELAY_BITS;
    localparam logic [SW:0] TMAX = {{(SW + 1 - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

    logic [bat_pkg::DELAY_BITS-1:0] wait_t;
    logic [SW:0]                    sum;
    logic [SW:0]                    sat;
    logic [SW:0]                    diff;

    always_comb begin
        if (i_cond.pressed) begin
            wait_t = i_cond.last ? i_repeat_interval : i_press_delay;
        end else begin
            wait_t = i_release_delay;
        end

        sum = (SW + 1)'(i_acc) + (SW + 1)'(i_dt);
        if (!(i_cond.pressed || i_cond.last)) begin
            sat = '0;
        end else if (sum > TMAX) begin
            sat = TMAX;
        end else begin
            sat = sum;
        end

        // borrow out of the subtract is the compare result
        diff = sat - (SW + 1)'(wait_t);

        o_res.hit   = !diff[SW];
        o_res.level = i_cond.pressed;
        o_acc       = o_res.hit ? diff[TIME_BITS-1:0] : sat[TIME_BITS-1:0];
    end

endmodule

// ===== design/button_autorepeat_timer.sv =====
// ----------------------------------------------------------------------------
// button_autorepeat_timer
// Key auto-repeat with press, repeat and release delays over a button word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one beat per poll, carrying the button level word and the
//   ticks elapsed since the previous poll. o_in_stall is high while a poll
//   is in progress (scan or flush). Output channel: one beat per report (button index,
//   level, and a flag set on the final report of the poll).
//   The scan visits one button per cycle, unless frozen by a stalled output,
//   through a single add/saturate and subtract unit. A poll takes the beat,
//   scans N buttons, N being the scanned button count (min of active_buttons
//   and NUM_BUTTONS), then releases the held final report.
//   A report is held so the final one can be flagged: it reaches the output
//   when the next report of the poll is found, or in the flush state.
//   A stalled output holds its beat and, once the next report needs the
//   output register, freezes the scan until the stall drops.
//   Reset clears all reported levels and accumulators at once and sets the
//   delays to zero and active_buttons to 32. Registers are to be written through
//   the APB port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "button_autorepeat_timer_macros.svh"

module button_autorepeat_timer #(
    parameter int NUM_BUTTONS = 32,
    parameter int TIME_BITS   = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bat_pkg::LEVEL_BITS-1:0]  i_button_levels,
    input  logic [bat_pkg::DELAY_BITS-1:0]  i_elapsed_ticks,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bat_pkg::INDEX_BITS-1:0]  o_button_index,
    output logic                            o_button_pressed,
    output logic                            o_last_report
);

    localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [bat_pkg::COUNT_BITS-1:0] NB = bat_pkg::COUNT_BITS'(NUM_BUTTONS);

    // configuration
    logic [bat_pkg::DELAY_BITS-1:0] r_press_delay;
    logic [bat_pkg::DELAY_BITS-1:0] r_repeat_interval;
    logic [bat_pkg::DELAY_BITS-1:0] r_release_delay;
    logic [bat_pkg::COUNT_BITS-1:0] r_active;
    logic                           cfg_wr;
    bat_pkg::t_reg_idx              cfg_idx;

    // button state
    logic [TIME_BITS-1:0]   r_acc [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_level;

    // sequencer
    bat_pkg::t_seq_state            r_state;
    bat_pkg::t_seq_state            n_state;
    logic [IW-1:0]                  r_idx;
    logic [bat_pkg::COUNT_BITS-1:0] r_count;
    logic [bat_pkg::LEVEL_BITS-1:0] r_levels;
    logic [bat_pkg::DELAY_BITS-1:0] r_dt;

    // pending report and output register
    logic                           r_pend_valid;
    logic [IW-1:0]                  r_pend_idx;
    logic                           r_pend_lvl;
    logic                           r_out_valid;
    logic [bat_pkg::INDEX_BITS-1:0] r_out_idx;
    logic                           r_out_lvl;
    logic                           r_out_last;

    logic                           in_accept;
    logic [bat_pkg::COUNT_BITS-1:0] count_eff;
    logic                           scan_end;
    logic                           out_free;
    logic                           step;
    logic                           out_load;
    logic                           out_last;
    logic                           pend_set;
    logic                           pend_clr;

    bat_pkg::t_step_in  cond;
    bat_pkg::t_step_res res;
    logic [TIME_BITS-1:0] unit_acc;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_delay     <= '0;
            r_repeat_interval <= '0;
            r_release_delay   <= '0;
            r_active          <= bat_pkg::ACTIVE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bat_pkg::REG_PRESS_DELAY: begin
                    r_press_delay <= pwdata[bat_pkg::DELAY_BITS-1:0];
                end
                bat_pkg::REG_REPEAT_INTERVAL: begin
                    r_repeat_interval <= pwdata[bat_pkg::DELAY_BITS-1:0];
                end
                bat_pkg::REG_RELEASE_DELAY: begin
                    r_release_delay <= pwdata[bat_pkg::DELAY_BITS-1:0];
                end
                bat_pkg::REG_ACTIVE_BUTTONS: begin
                    r_active <= pwdata[bat_pkg::COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bat_pkg::REG_PRESS_DELAY:     prdata = 32'(r_press_delay);
            bat_pkg::REG_REPEAT_INTERVAL: prdata = 32'(r_repeat_interval);
            bat_pkg::REG_RELEASE_DELAY:   prdata = 32'(r_release_delay);
            bat_pkg::REG_ACTIVE_BUTTONS:  prdata = 32'(r_active);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Shared time unit
    // ------------------------------------------------------------------------
    assign cond.pressed = r_levels[r_idx];
    assign cond.last    = r_level[r_idx];

    bat_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_unit (
        .i_acc             (r_acc[r_idx]),
        .i_dt              (r_dt),
        .i_press_delay     (r_press_delay),
        .i_repeat_interval (r_repeat_interval),
        .i_release_delay   (r_release_delay),
        .i_cond            (cond),
        .o_acc             (unit_acc),
        .o_res             (res)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign count_eff = (r_active > NB) ? NB : r_active;
    assign in_accept = i_in_valid && !o_in_stall;
    assign scan_end  = (bat_pkg::COUNT_BITS'(r_idx) == r_count - 1'b1);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            bat_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = (count_eff == '0) ? bat_pkg::ST_FLUSH : bat_pkg::ST_SCAN;
                end
            end
            bat_pkg::ST_SCAN: begin
                if (step && scan_end) begin
                    n_state = bat_pkg::ST_FLUSH;
                end
            end
            bat_pkg::ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = bat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        step       = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;
        pend_set   = 1'b0;
        pend_clr   = 1'b0;
        case (r_state)
            bat_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            bat_pkg::ST_SCAN: begin
                // hold the scan while a new report would push into a full output
                step = !(res.hit && r_pend_valid && !out_free);
                if (step && res.hit) begin
                    pend_set = 1'b1;
                    out_load = r_pend_valid;
                end
            end
            bat_pkg::ST_FLUSH: begin
                if (r_pend_valid && out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    pend_clr = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
        end else if (in_accept) begin
            r_idx   <= '0;
            r_count <= count_eff;
        end else if (step && !scan_end) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_levels <= i_button_levels;
            r_dt     <= i_elapsed_ticks;
        end
    end

    // ------------------------------------------------------------------------
    // Button state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_acc[k] <= '0;
            end
            r_level <= '0;
        end else if (step) begin
            r_acc[r_idx] <= unit_acc;
            if (res.hit) begin
                r_level[r_idx] <= res.level;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pending report and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (pend_set) begin
            r_pend_valid <= 1'b1;
        end else if (pend_clr) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_set) begin
            r_pend_idx <= r_idx;
            r_pend_lvl <= res.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= bat_pkg::INDEX_BITS'(r_pend_idx);
            r_out_lvl  <= r_pend_lvl;
            r_out_last <= out_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_button_index   = r_out_idx;
    assign o_button_pressed = r_out_lvl;
    assign o_last_report    = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BAT_ASSERT_NOW(a_idle_no_pend, r_state == bat_pkg::ST_IDLE, !r_pend_valid)
    `BAT_ASSERT_NOW(a_scan_in_range, r_state == bat_pkg::ST_SCAN,
        bat_pkg::COUNT_BITS'(r_idx) < r_count)
    `BAT_ASSERT_NEXT(a_flush_last,
        r_state == bat_pkg::ST_FLUSH && r_pend_valid && out_free,
        o_out_valid && o_last_report)
    `BAT_ASSERT_NEXT(a_scan_not_last,
        r_state == bat_pkg::ST_SCAN && out_load, o_out_valid && !o_last_report)

endmodule

// ===== bench/button_autorepeat_timer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_autorepeat_timer_tb
// Self-checking bench for the button auto-repeat timer. Polls go in through
// the valid/stall channel and the delays through the APB port. A local copy
// of the per-button timers predicts every report. Each output beat is
// compared against the oldest predicted report. Both channels idle at random
// and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module button_autorepeat_timer_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_PERCENT = 37;
    localparam int DB           = bat_pkg::DELAY_BITS;
    localparam int LB           = bat_pkg::LEVEL_BITS;
    localparam int IB           = bat_pkg::INDEX_BITS;
    localparam int CB           = bat_pkg::COUNT_BITS;

    typedef struct {
        logic [IB-1:0] index;
        logic          pressed;
        logic          final_flag;
    } t_button_report;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          psel            = 1'b0;
    logic          penable         = 1'b0;
    logic          pwrite          = 1'b0;
    logic [3:0]    paddr           = '0;
    logic [31:0]   pwdata          = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          i_in_valid      = 1'b0;
    logic          o_in_stall;
    logic [LB-1:0] i_button_levels = '0;
    logic [DB-1:0] i_elapsed_ticks = '0;
    logic          o_out_valid;
    logic          i_out_stall     = 1'b0;
    logic [IB-1:0] o_button_index;
    logic          o_button_pressed;
    logic          o_last_report;

    // Local copy of the registers and the per-button timers
    logic [DB-1:0] press_dly   = '0;
    logic [DB-1:0] repeat_ivl  = '0;
    logic [DB-1:0] release_dly = '0;
    logic [CB-1:0] active_cnt  = bat_pkg::ACTIVE_RESET;
    logic          shown_level [32];
    logic [DB-1:0] held_time   [32];

    t_button_report reports_due[$];
    logic [LB-1:0]  live_levels  = '0;
    int             error_count  = 0;
    int             cycle_count  = 0;
    bit             no_idle      = 1'b0;
    int             holdoff_req  = 0;
    int             holdoff_left = 0;

    button_autorepeat_timer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_button_levels  (i_button_levels),
        .i_elapsed_ticks  (i_elapsed_ticks),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_button_index   (o_button_index),
        .o_button_pressed (o_button_pressed),
        .o_last_report    (o_last_report)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("button_autorepeat_timer_tb failed");
            $finish;
        end
    end

    // Receiver: random stall, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (holdoff_req > 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Outputs settle by the falling edge; a beat seen here is taken at the next rise
    always @(negedge i_clk) begin : report_check
        t_button_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                $error("unexpected report: button_index %0d, button_pressed %0d",
                       o_button_index, o_button_pressed);
                error_count++;
            end else begin
                want = reports_due.pop_front();
                if (o_button_index !== want.index) begin
                    $error("button_index: expected %0d, got %0d", want.index, o_button_index);
                    error_count++;
                end
                if (o_button_pressed !== want.pressed) begin
                    $error("button_pressed: expected %0d, got %0d",
                           want.pressed, o_button_pressed);
                    error_count++;
                end
                if (o_last_report !== want.final_flag) begin
                    $error("last_report: expected %0d, got %0d",
                           want.final_flag, o_last_report);
                    error_count++;
                end
            end
        end
    end

    // Scan the active buttons of one poll and queue the reports it causes
    task automatic advance_timers(input logic [LB-1:0] levels,
                                  input logic [DB-1:0] ticks);
        int             scan_n;
        int             queued_before;
        logic [DB:0]    sum;
        logic [DB-1:0]  due;
        logic [DB-1:0]  acc;
        logic           now_pressed;
        logic           was_pressed;
        t_button_report rep;
        scan_n        = (active_cnt > 6'd32) ? 32 : int'(active_cnt);
        queued_before = reports_due.size();
        for (int j = 0; j < scan_n; j++) begin
            now_pressed = levels[j];
            was_pressed = shown_level[j];
            if (now_pressed)
                due = was_pressed ? repeat_ivl : press_dly;
            else
                due = release_dly;
            if (now_pressed || was_pressed) begin
                sum = {1'b0, held_time[j]} + {1'b0, ticks};
                acc = sum[DB] ? {DB{1'b1}} : sum[DB-1:0];
            end else begin
                acc = '0;
            end
            if (acc >= due) begin
                shown_level[j] = now_pressed;
                acc            = acc - due;
                rep.index      = IB'(j);
                rep.pressed    = now_pressed;
                rep.final_flag = 1'b0;
                reports_due.push_back(rep);
            end
            held_time[j] = acc;
        end
        // Flag the final report of this poll
        if (reports_due.size() > queued_before) begin
            rep            = reports_due.pop_back();
            rep.final_flag = 1'b1;
            reports_due.push_back(rep);
        end
    endtask

    // Offer one poll beat and hold it until it is taken
    task automatic send_poll(input logic [LB-1:0] levels,
                             input logic [DB-1:0] ticks);
        logic stalled;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_button_levels <= levels;
        i_elapsed_ticks <= ticks;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        advance_timers(levels, ticks);
    endtask

    // Setup and access phases, then an idle wait before the next transfer
    task automatic write_reg(input bat_pkg::t_reg_idx idx, input logic [31:0] value);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bat_pkg::REG_PRESS_DELAY:     press_dly   = value[DB-1:0];
            bat_pkg::REG_REPEAT_INTERVAL: repeat_ivl  = value[DB-1:0];
            bat_pkg::REG_RELEASE_DELAY:   release_dly = value[DB-1:0];
            bat_pkg::REG_ACTIVE_BUTTONS:  active_cnt  = value[CB-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every report, then let a silent scan finish
    task automatic drain_reports;
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_delays(input logic [DB-1:0] pd, input logic [DB-1:0] ri,
                               input logic [DB-1:0] rd, input logic [CB-1:0] act);
        drain_reports();
        write_reg(bat_pkg::REG_PRESS_DELAY, 32'(pd));
        write_reg(bat_pkg::REG_REPEAT_INTERVAL, 32'(ri));
        write_reg(bat_pkg::REG_RELEASE_DELAY, 32'(rd));
        write_reg(bat_pkg::REG_ACTIVE_BUTTONS, 32'(act));
    endtask

    // Zero waits after reset: every scanned button reports on every poll
    task automatic test_reset_defaults;
        send_poll('0, '0);
        send_poll('1, {DB{1'b1}});
        send_poll(32'h0F0F_00FF, 24'd1);
    endtask

    // New press, held repeat, release, carry-over of surplus ticks, saturation
    task automatic test_directed_timing;
        load_delays(24'd10, 24'd5, 24'd3, 6'd4);
        send_poll(32'h0, 24'd7);
        send_poll(32'h1, 24'd4);
        send_poll(32'h1, 24'd6);
        send_poll(32'h1, 24'd5);
        send_poll(32'h1, 24'd12);
        send_poll(32'h0, 24'd2);
        send_poll(32'h0, 24'd1);
        send_poll(32'hF, {DB{1'b1}});
        send_poll(32'hF, {DB{1'b1}});
        send_poll(32'h0, 24'd0);
    endtask

    // Waits at the top of the range are met only by a saturated accumulator
    task automatic test_delay_extremes;
        load_delays({DB{1'b1}}, {DB{1'b1}}, {DB{1'b1}}, 6'd32);
        send_poll('1, {DB{1'b1}});
        send_poll('1, 24'd1);
        send_poll('1, {DB{1'b1}});
        send_poll('0, 24'h80_0000);
        send_poll('0, 24'h7F_FFFF);
    endtask

    // No buttons, one button, too many buttons, and unscanned buttons keeping state
    task automatic test_button_count;
        load_delays('0, '0, '0, 6'd0);
        send_poll('1, 24'd5);
        send_poll('0, 24'd5);
        load_delays('0, '0, '0, 6'd63);
        send_poll(32'hA5A5_A5A5, 24'd0);
        load_delays('0, '0, '0, 6'd1);
        send_poll('1, 24'd0);
        load_delays(24'd2, 24'd2, 24'd2, 6'd40);
        send_poll(32'h5A5A_5A5A, 24'd3);
    endtask

    task automatic run_random_phase(input int polls, input logic [DB-1:0] pd,
                                    input logic [DB-1:0] ri,
                                    input logic [DB-1:0] rd,
                                    input logic [CB-1:0] act,
                                    input logic [DB-1:0] tick_span, input bit steady);
        int            pick;
        logic [DB-1:0] ticks;
        load_delays(pd, ri, rd, act);
        no_idle = steady;
        repeat (polls) begin
            // Mostly held buttons with the odd flip, so repeats and releases get reached
            pick = $urandom_range(99);
            if (pick < 75)
                live_levels ^= $urandom & $urandom & $urandom;
            else if (pick < 85)
                live_levels = $urandom;
            else if (pick < 92)
                live_levels = '0;
            else
                live_levels = '1;
            pick = $urandom_range(99);
            if (pick < 85)
                ticks = DB'($urandom_range(int'(tick_span), 0));
            else if (pick < 93)
                ticks = '0;
            else
                ticks = DB'($urandom);
            send_poll(live_levels, ticks);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_settings;
        run_random_phase(80, 24'd20, 24'd8, 24'd12, 6'd32, 24'd10, 1'b0);
        run_random_phase(60, 24'd0, 24'd0, 24'd0, 6'd7, 24'd5, 1'b0);
        run_random_phase(50, {DB{1'b1}}, 24'd1, {DB{1'b1}}, 6'd32,
                         {DB{1'b1}}, 1'b0);
        run_random_phase(80, DB'($urandom_range(100)), DB'($urandom_range(100)),
                         DB'($urandom_range(100)), CB'($urandom_range(32, 1)),
                         24'd60, 1'b1);
        run_random_phase(70, 24'd3, 24'd50, 24'd0, 6'd63, 24'd30, 1'b0);
        run_random_phase(80, DB'($urandom_range(40)), DB'($urandom_range(40)),
                         DB'($urandom_range(40)), CB'($urandom_range(63)),
                         24'd25, 1'b0);
    endtask

    // Long receiver hold-off while polls keep coming: the block must stall its input
    task automatic test_backpressure;
        load_delays('0, '0, '0, 6'd32);
        no_idle     = 1'b1;
        holdoff_req = 400;
        repeat (30) send_poll($urandom, DB'($urandom_range(50)));
        no_idle = 1'b0;
    endtask

    initial begin
        for (int j = 0; j < 32; j++) begin
            shown_level[j] = 1'b0;
            held_time[j]   = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_timing();
        test_delay_extremes();
        test_button_count();
        test_random_settings();
        test_backpressure();

        drain_reports();
        if (error_count == 0)
            $display("button_autorepeat_timer_tb passed");
        else
            $display("button_autorepeat_timer_tb failed");
        $finish;
    end

endmodule
